// ===== rtl/xmhd_pkg.sv =====
// Shared types, codes and constants for the masked-header deframer.
// No dependencies; imported by xmhd_step and xor_masked_header_deframer.
`default_nettype none

package xmhd_pkg;

  // Fixed header: 2 check bytes, 4 full length bytes, 2 name length bytes
  localparam int unsigned FIXED_HEADER_BYTES = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_XOR_MASK     = 2'd0;
  localparam logic [1:0] REG_CHECK_FIRST  = 2'd1;
  localparam logic [1:0] REG_CHECK_SECOND = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_BODY    = 2'd2;
  localparam logic [1:0] KIND_NO_NAME = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CHECK_BAD = 2'd1;
  localparam logic [1:0] ST_LEN_BAD   = 2'd2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_CHK0 = 3'd0,
    PH_CHK1 = 3'd1,
    PH_FULL = 3'd2,
    PH_NLEN = 3'd3,
    PH_NAME = 3'd4,
    PH_BODY = 3'd5
  } phase_t;

  // Parser state carried from beat to beat
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  byte_index;
    logic        first_matched;
    logic [31:0] length_shift;
    logic [15:0] name_shift;
    logic [15:0] name_left;
    logic [31:0] body_left;
  } state_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0] xor_mask;
    logic [7:0] check_first;
    logic [7:0] check_second;
  } config_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [31:0] frame_length;
    logic [15:0] name_length;
    logic        frame_end;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/xmhd_step.sv =====
// Next-state and result logic for one received byte of the deframer.
// Depends on xmhd_pkg for the state, config and result types.
`default_nettype none

module xmhd_step
  import xmhd_pkg::*;
(
  input  state_t     st,
  input  config_t    cfg,
  input  logic [7:0] in_byte,
  output state_t     st_next,
  output result_t    res
);

  logic [7:0]  clear_byte;
  logic        flen_known;
  logic        nlen_known;
  logic [31:0] len_new;
  logic [15:0] name_new;
  logic [15:0] name_left_dec;
  logic [31:0] body_left_dec;
  logic [32:0] hdr_len;
  logic        len_short;
  logic [31:0] body_len;

  // Unmask and prepare shifted lengths and the header length compare
  assign clear_byte    = in_byte ^ cfg.xor_mask;
  assign len_new       = {st.length_shift[23:0], clear_byte};
  assign name_new      = {st.name_shift[7:0], clear_byte};
  assign name_left_dec = st.name_left - 16'd1;
  assign body_left_dec = st.body_left - 32'd1;
  assign hdr_len       = 33'(FIXED_HEADER_BYTES) + {17'd0, name_new};
  assign len_short     = {1'b0, st.length_shift} < hdr_len;
  assign body_len      = st.length_shift - hdr_len[31:0];

  // Advance the parser by one byte
  always_comb begin
    st_next      = st;
    res.kind     = KIND_HEADER;
    res.out_byte = 8'd0;
    res.status   = ST_OK;
    res.frame_end = 1'b0;
    flen_known   = (st.phase == PH_NLEN) || (st.phase == PH_NAME) || (st.phase == PH_BODY);
    nlen_known   = (st.phase == PH_NAME) || (st.phase == PH_BODY);

    unique case (st.phase)
      PH_CHK1: begin
        if (st.first_matched && (clear_byte == cfg.check_second)) begin
          st_next.phase        = PH_FULL;
          st_next.byte_index   = 2'd0;
          st_next.length_shift = 32'd0;
        end else begin
          res.status            = ST_CHECK_BAD;
          st_next.phase         = PH_CHK0;
          st_next.byte_index    = 2'd0;
          st_next.first_matched = 1'b0;
        end
      end
      PH_FULL: begin
        st_next.length_shift = len_new;
        if (st.byte_index == 2'd3) begin
          flen_known = 1'b1;
          if (len_new < 32'(FIXED_HEADER_BYTES)) begin
            res.status            = ST_LEN_BAD;
            st_next.phase         = PH_CHK0;
            st_next.byte_index    = 2'd0;
            st_next.first_matched = 1'b0;
          end else begin
            st_next.phase      = PH_NLEN;
            st_next.byte_index = 2'd0;
            st_next.name_shift = 16'd0;
          end
        end else begin
          st_next.byte_index = st.byte_index + 2'd1;
        end
      end
      PH_NLEN: begin
        st_next.name_shift = name_new;
        if (st.byte_index != 2'd0) begin
          nlen_known = 1'b1;
          if (len_short) begin
            res.status            = ST_LEN_BAD;
            st_next.phase         = PH_CHK0;
            st_next.byte_index    = 2'd0;
            st_next.first_matched = 1'b0;
          end else begin
            st_next.body_left  = body_len;
            st_next.name_left  = name_new;
            st_next.byte_index = 2'd0;
            if (name_new != 16'd0) begin
              st_next.phase = PH_NAME;
            end else begin
              res.kind = KIND_NO_NAME;
              if (body_len == 32'd0) begin
                res.frame_end         = 1'b1;
                st_next.phase         = PH_CHK0;
                st_next.first_matched = 1'b0;
              end else begin
                st_next.phase = PH_BODY;
              end
            end
          end
        end else begin
          st_next.byte_index = 2'd1;
        end
      end
      PH_NAME: begin
        res.kind          = KIND_NAME;
        res.out_byte      = clear_byte;
        st_next.name_left = name_left_dec;
        if (name_left_dec == 16'd0) begin
          if (st.body_left == 32'd0) begin
            res.frame_end         = 1'b1;
            st_next.phase         = PH_CHK0;
            st_next.byte_index    = 2'd0;
            st_next.first_matched = 1'b0;
          end else begin
            st_next.phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        res.kind          = KIND_BODY;
        res.out_byte      = in_byte;
        st_next.body_left = body_left_dec;
        if (body_left_dec == 32'd0) begin
          res.frame_end         = 1'b1;
          st_next.phase         = PH_CHK0;
          st_next.byte_index    = 2'd0;
          st_next.first_matched = 1'b0;
        end
      end
      default: begin
        // First check code byte; unused codes also land here
        st_next.first_matched = (clear_byte == cfg.check_first);
        st_next.phase         = PH_CHK1;
        st_next.byte_index    = 2'd0;
      end
    endcase

    res.frame_length = flen_known ? st_next.length_shift : 32'd0;
    res.name_length  = nlen_known ? st_next.name_shift : 16'd0;
  end

endmodule

`default_nettype wire

// ===== rtl/xor_masked_header_deframer.sv =====
// Top level of the masked-header deframer: config, state and result registers.
// Depends on xmhd_pkg and xmhd_step.
`default_nettype none

// Takes one received byte per clock and returns one result beat per byte.
// Each byte passes through a single combinational step between the parser
// state registers and the result register, so the sustained rate is one byte
// per cycle and the result appears in the cycle after the byte is accepted. The
// input is stalled only while a result is held and the output side stalls.
// Header bytes are unmasked with xor_mask, the check code is compared with
// check_first/check_second, and lengths are validated; on any error or at the
// end of a frame the parser looks for a new header with the next byte. The user must
// write configuration through cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
module xor_masked_header_deframer
  import xmhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic [31:0] frame_length,
  output logic [15:0] name_length,
  output logic        frame_end
);

  config_t cfg;
  state_t  st;
  state_t  st_next;
  result_t res;
  logic    in_take;

  // Accept a byte when the result register is free or being drained
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_XOR_MASK:     cfg.xor_mask     <= cfg_data;
        REG_CHECK_FIRST:  cfg.check_first  <= cfg_data;
        REG_CHECK_SECOND: cfg.check_second <= cfg_data;
        default: ;
      endcase
    end
  end

  xmhd_step u_step (
    .st      (st),
    .cfg     (cfg),
    .in_byte (in_byte),
    .st_next (st_next),
    .res     (res)
  );

  // Parser state: advance on each accepted beat; all-zero state is PH_CHK0
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // Result valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind         <= res.kind;
      out_byte     <= res.out_byte;
      status       <= res.status;
      frame_length <= res.frame_length;
      name_length  <= res.name_length;
      frame_end    <= res.frame_end;
    end
  end

  // An error beat never ends a frame and is always a header beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (kind == KIND_HEADER) && !frame_end)
    else $error("error result with non-header kind or frame end");

  // After a frame end or an error the parser restarts at a new header
  assert property (@(posedge clk) disable iff (rst)
    in_take && (res.frame_end || (res.status != ST_OK)) |=> st.phase == PH_CHK0)
    else $error("parser did not restart after frame end or error");

  // Body phase always has bytes left to pass
  assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_BODY |-> st.body_left != 32'd0)
    else $error("body phase with zero bytes left");

  // Name phase always has name bytes left
  assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_NAME |-> st.name_left != 16'd0)
    else $error("name phase with zero name bytes left");

  // A name byte always comes with a known, nonzero name length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NAME) |-> name_length != 16'd0)
    else $error("name byte without name length");

endmodule

`default_nettype wire

// ===== verif/xor_masked_header_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for xor_masked_header_deframer: directed headers, then random frames.
// Depends on xmhd_pkg and the deframer RTL; an in-bench parser predicts every result beat.

module xor_masked_header_deframer_tb;
  import xmhd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [31:0] frame_length;
  logic [15:0] name_length;
  logic        frame_end;

  // Bench copy of the configuration registers
  logic [7:0] mask_reg;
  logic [7:0] chk_a;
  logic [7:0] chk_b;

  // Bench copy of the parser state
  phase_t      ph;
  logic [1:0]  idx;
  logic        first_ok;
  logic [31:0] flen_acc;
  logic [15:0] nlen_acc;
  logic [15:0] name_rem;
  logic [31:0] body_rem;

  result_t     expected_beats[$];
  logic [7:0]  frame_bytes[$];
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  xor_masked_header_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .status       (status),
    .frame_length (frame_length),
    .name_length  (name_length),
    .frame_end    (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  function automatic void resync_parser();
    ph = PH_CHK0;
    idx = 2'd0;
    first_ok = 1'b0;
  endfunction

  // Advance the parser by one raw byte and return the beat it produces
  function automatic result_t deframe_byte(input logic [7:0] raw);
    result_t     r;
    logic [7:0]  clr;
    logic        flen_ok;
    logic        nlen_ok;
    logic [31:0] hdr_len;
    r = '0;
    clr = raw ^ mask_reg;
    flen_ok = (ph == PH_NLEN || ph == PH_NAME || ph == PH_BODY);
    nlen_ok = (ph == PH_NAME || ph == PH_BODY);
    case (ph)
      PH_CHK1: begin
        if (first_ok && clr == chk_b) begin
          ph = PH_FULL;
          idx = 2'd0;
          flen_acc = '0;
        end else begin
          r.status = ST_CHECK_BAD;
          resync_parser();
        end
      end
      PH_FULL: begin
        flen_acc = {flen_acc[23:0], clr};
        if (idx == 2'd3) begin
          flen_ok = 1'b1;
          if (flen_acc < FIXED_HEADER_BYTES) begin
            r.status = ST_LEN_BAD;
            resync_parser();
          end else begin
            ph = PH_NLEN;
            idx = 2'd0;
            nlen_acc = '0;
          end
        end else begin
          idx = idx + 2'd1;
        end
      end
      PH_NLEN: begin
        nlen_acc = {nlen_acc[7:0], clr};
        if (idx != 2'd0) begin
          hdr_len = FIXED_HEADER_BYTES + nlen_acc;
          nlen_ok = 1'b1;
          if (flen_acc < hdr_len) begin
            r.status = ST_LEN_BAD;
            resync_parser();
          end else begin
            body_rem = flen_acc - hdr_len;
            name_rem = nlen_acc;
            idx = 2'd0;
            if (nlen_acc != 16'd0) begin
              ph = PH_NAME;
            end else begin
              r.kind = KIND_NO_NAME;
              if (body_rem == 32'd0) begin
                r.frame_end = 1'b1;
                resync_parser();
              end else begin
                ph = PH_BODY;
              end
            end
          end
        end else begin
          idx = 2'd1;
        end
      end
      PH_NAME: begin
        r.kind = KIND_NAME;
        r.out_byte = clr;
        name_rem = name_rem - 16'd1;
        if (name_rem == 16'd0) begin
          if (body_rem == 32'd0) begin
            r.frame_end = 1'b1;
            resync_parser();
          end else begin
            ph = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        r.kind = KIND_BODY;
        r.out_byte = raw;
        body_rem = body_rem - 32'd1;
        if (body_rem == 32'd0) begin
          r.frame_end = 1'b1;
          resync_parser();
        end
      end
      default: begin
        // first check code byte
        first_ok = (clr == chk_a);
        ph = PH_CHK1;
        idx = 2'd0;
      end
    endcase
    r.frame_length = flen_ok ? flen_acc : 32'd0;
    r.name_length = nlen_ok ? nlen_acc : 16'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and output stall
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    $display("%0t mismatch %s: expected %0h actual %0h", $time, field, exp_v, got_v);
    mismatch_count++;
  endtask

  // Compare each accepted beat with the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none actual kind %0h byte %0h status %0h",
                 $time, kind, out_byte, status);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (kind !== want.kind) note_mismatch("kind", want.kind, kind);
        if (out_byte !== want.out_byte) note_mismatch("out_byte", want.out_byte, out_byte);
        if (status !== want.status) note_mismatch("status", want.status, status);
        if (frame_length !== want.frame_length)
          note_mismatch("frame_length", want.frame_length, frame_length);
        if (name_length !== want.name_length)
          note_mismatch("name_length", want.name_length, name_length);
        if (frame_end !== want.frame_end) note_mismatch("frame_end", want.frame_end, frame_end);
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one byte, hold it until accepted, then record its expected beat
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    expected_beats.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
  endtask

  // Hold off the sender until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      REG_XOR_MASK:    mask_reg = value;
      REG_CHECK_FIRST: chk_a = value;
      default:         chk_b = value;
    endcase
  endtask

  task automatic set_config(input logic [7:0] mask, input logic [7:0] first,
                            input logic [7:0] second);
    drain_results();
    write_reg(REG_XOR_MASK, mask);
    write_reg(REG_CHECK_FIRST, first);
    write_reg(REG_CHECK_SECOND, second);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push_masked(input logic [7:0] b);
    frame_bytes.push_back(b ^ mask_reg);
  endfunction

  // Queue the 8 fixed header bytes, given in clear
  function automatic void build_header(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [31:0] full, input logic [15:0] nlen);
    push_masked(c0);
    push_masked(c1);
    for (int i = 3; i >= 0; i--) push_masked(full[8*i +: 8]);
    push_masked(nlen[15:8]);
    push_masked(nlen[7:0]);
  endfunction

  task automatic send_good_frame(input int unsigned n_name, input int unsigned n_body);
    build_header(chk_a, chk_b, FIXED_HEADER_BYTES + n_name + n_body, 16'(n_name));
    repeat (n_name) push_masked(8'($urandom));
    repeat (n_body) frame_bytes.push_back(8'($urandom));
    send_queued();
  endtask

  // Full length below the fixed header: stop after the last length byte
  task automatic send_short_full(input logic [31:0] full);
    build_header(chk_a, chk_b, full, 16'd0);
    void'(frame_bytes.pop_back());
    void'(frame_bytes.pop_back());
    send_queued();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset value: empty name and empty body ends on the header
  task automatic test_reset_defaults();
    send_good_frame(0, 0);
  endtask

  // Bad first byte, then good first byte with bad second byte
  task automatic test_check_code();
    push_masked(~chk_a);
    push_masked(chk_b);
    push_masked(chk_a);
    push_masked(~chk_b);
    send_queued();
  endtask

  // Full length below 8, and full length shorter than the header with a maximal name
  task automatic test_bad_lengths();
    send_short_full(32'd7);
    build_header(chk_a, chk_b, FIXED_HEADER_BYTES + 32'hFFFE, 16'hFFFF);
    send_queued();
  endtask

  // Name longer than one length byte can hold
  task automatic test_long_name();
    send_good_frame(300, 5);
  endtask

  // Mostly well-formed frames with random content, some broken headers
  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n_name;
    int unsigned n_body;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [15:0] nlen;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(9);
        n_name = (pick < 3) ? 0 : (pick < 8) ? $urandom_range(1, 4) : $urandom_range(5, 24);
        pick = $urandom_range(9);
        n_body = (pick < 3) ? 0 : (pick < 8) ? $urandom_range(1, 8) : $urandom_range(9, 64);
        send_good_frame(n_name, n_body);
      end else if (pick < 82) begin
        c0 = 8'($urandom);
        c1 = 8'($urandom);
        if (c0 == chk_a && c1 == chk_b) c1 = c1 ^ 8'h01;
        push_masked(c0);
        push_masked(c1);
        send_queued();
      end else if (pick < 90) begin
        send_short_full($urandom_range(0, 7));
      end else begin
        nlen = 16'($urandom_range(1, 65535));
        build_header(chk_a, chk_b, FIXED_HEADER_BYTES + $urandom_range(0, nlen - 1), nlen);
        send_queued();
      end
      // Now and then let the pipeline empty completely
      if ($urandom_range(24) == 0) drain_results();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_XOR_MASK;
    cfg_data <= 8'd0;
    in_valid <= 1'b0;
    in_byte <= 8'd0;
    mismatch_count = 0;
    bytes_sent = 0;
    mask_reg = 8'd0;
    chk_a = 8'd0;
    chk_b = 8'd0;
    resync_parser();
    flen_acc = '0;
    nlen_acc = '0;
    name_rem = '0;
    body_rem = '0;
    send_idle_pct = 7;
    recv_stall_pct = 68;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_check_code();
    test_bad_lengths();

    set_config(8'hFF, 8'hFF, 8'h00);
    test_random_stream(225);

    send_idle_pct = 68;
    recv_stall_pct = 7;
    set_config(8'h00, 8'h00, 8'hFF);
    test_random_stream(225);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    test_long_name();
    test_random_stream(225);

    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    test_random_stream(225);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
